>>> rtl/tot_pkg.sv
// Shared types, codes and constants of the periodic and one-shot timer table.
package tot_pkg;

	localparam int PERIODIC_SLOTS_DEF = 16;
	localparam int ONCE_SLOTS_DEF     = 16;
	localparam int RESULT_LIMIT       = 32;
	localparam int NW                 = $clog2(RESULT_LIMIT + 1);

	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_ADD_PER  = 2'd1;
	localparam logic [1:0] OP_ADD_ONCE = 2'd2;
	localparam logic [1:0] OP_REMOVE   = 2'd3;

	localparam logic [2:0] ST_FIRED     = 3'd0;
	localparam logic [2:0] ST_ADDED     = 3'd1;
	localparam logic [2:0] ST_REMOVED   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	// Datapath command codes.
	localparam logic [3:0] C_NOP       = 4'd0;
	localparam logic [3:0] C_LOAD      = 4'd1;
	localparam logic [3:0] C_ADD       = 4'd2;
	localparam logic [3:0] C_RD        = 4'd3;
	localparam logic [3:0] C_SUM       = 4'd4;
	localparam logic [3:0] C_FIRE      = 4'd5;
	localparam logic [3:0] C_DIVGO     = 4'd6;
	localparam logic [3:0] C_WRACC     = 4'd7;
	localparam logic [3:0] C_NEXTP     = 4'd8;
	localparam logic [3:0] C_SHINIT    = 4'd9;
	localparam logic [3:0] C_SHRD      = 4'd10;
	localparam logic [3:0] C_SHWR      = 4'd11;
	localparam logic [3:0] C_DEC       = 4'd12;
	localparam logic [3:0] C_NOTF      = 4'd13;
	localparam logic [3:0] C_ONCE_INIT = 4'd14;
	localparam logic [3:0] C_EMIT      = 4'd15;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  listener_id;
		logic [15:0] event_id;
		logic [31:0] period;
		logic [31:0] elapsed;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  fired_listener;
		logic [15:0] fired_event;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0]  lsn;
		logic [15:0] evt;
		logic [31:0] per;
		logic [31:0] acc;
	} entry_t;

	typedef struct packed {
		logic [3:0] code;
		logic       tbl;
		logic       flush;
	} cmd_t;

	typedef struct packed {
		logic i_end;
		logic o_zero;
		logic shift_end;
		logic match;
		logic due;
		logic div_done;
		logic out_free;
		logic pend_v;
		logic fire_ok;
	} sts_t;

endpackage

>>> rtl/periodic_and_oneshot_timer_table_top.sv
// Top level of the periodic and one-shot timer table.
// The item channel (item_valid, item_stall, item) carries one operation per
// transaction: tick, add periodic, add one-shot or remove periodic. The result
// channel (result_valid, result_stall, result) returns one transaction per
// add or remove, and one per fired timer on a tick up to 32 of them, the
// final one with last set; a tick where nothing fires returns nothing.
// Items are handled one at a time; item_stall is high while an item is in work.
// An add writes the next free slot of its table, and a remove searches the
// periodic table entry by entry and moves each later entry up. A tick visits
// each entry, runs the bit-serial remainder unit once per due periodic timer,
// and moves the later one-shot entries up after a one-shot fires.
// Results leave through an output register; while the receiver stalls the
// register holds its value and the sequencer waits before its next result.
// Reset empties both tables and the output register at once; no clearing pass.
module periodic_and_oneshot_timer_table_top #(
	parameter int PERIODIC_SLOTS = tot_pkg::PERIODIC_SLOTS_DEF,
	parameter int ONCE_SLOTS     = tot_pkg::ONCE_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tot_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output tot_pkg::result_t result
);
	tot_pkg::cmd_t cmd;
	tot_pkg::sts_t sts;

	tot_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.operation),
		.sts        (sts),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	tot_dp #(
		.PS (PERIODIC_SLOTS),
		.OS (ONCE_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.sts          (sts)
	);
endmodule

>>> rtl/tot_div.sv
// Restoring divider that yields the 32-bit remainder, one bit per cycle.
module tot_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] rem
);
	logic [31:0] rem_q, dvd_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] t;

	assign t    = {rem_q, dvd_q[31]};
	assign done = done_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				rem_q <= 32'(t - {1'b0, divisor});
			end else begin
				rem_q <= t[31:0];
			end
		end
	end
endmodule

>>> rtl/tot_dp.sv
// Datapath: both timer tables, counts, result staging and the output register.
module tot_dp #(
	parameter int PS = tot_pkg::PERIODIC_SLOTS_DEF,
	parameter int OS = tot_pkg::ONCE_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tot_pkg::cmd_t    cmd,
	input  tot_pkg::item_t   item,
	input  logic             result_stall,
	output logic             result_valid,
	output tot_pkg::result_t result,
	output tot_pkg::sts_t    sts
);
	localparam int MAXS = (PS > OS) ? PS : OS;
	localparam int IW   = $clog2(MAXS + 1);
	localparam int APW  = (PS > 1) ? $clog2(PS) : 1;
	localparam int AOW  = (OS > 1) ? $clog2(OS) : 1;

	tot_pkg::entry_t pmem [PS];
	tot_pkg::entry_t omem [OS];
	tot_pkg::entry_t rdp_q, rdo_q, rd, wd;

	logic [7:0]  lis_q;
	logic [15:0] ev_q;
	logic [31:0] per_q, el_q, acc_q, wacc, div_rem;
	logic [2:0]  st_q;
	logic [IW-1:0] pcnt_q, ocnt_q, idx_q, j_q, cnt, base, addr;
	logic [7:0]  pend_lsn_q;
	logic [15:0] pend_evt_q;
	logic        pend_v_q, out_v_q, div_done, we, full, n_full, out_free, push;
	logic [tot_pkg::NW-1:0] n_q;
	logic [32:0] s;
	tot_pkg::result_t out_q, push_data;

	assign rd   = cmd.tbl ? rdo_q : rdp_q;
	assign cnt  = cmd.tbl ? ocnt_q : pcnt_q;
	assign base = cmd.tbl ? idx_q - IW'(1) : idx_q;
	assign full = cmd.tbl ? (ocnt_q == IW'(OS)) : (pcnt_q == IW'(PS));
	assign s    = {1'b0, rd.acc} + {1'b0, el_q};
	assign n_full   = (n_q == tot_pkg::NW'(tot_pkg::RESULT_LIMIT));
	assign out_free = !out_v_q || !result_stall;

	always_comb begin
		case (cmd.code)
			tot_pkg::C_ADD:  addr = cnt;
			tot_pkg::C_SHRD: addr = j_q + IW'(1);
			tot_pkg::C_SHWR: addr = j_q;
			default:         addr = base;
		endcase
	end

	assign wacc = (acc_q < rd.per) ? acc_q : ((rd.per == 32'd0) ? 32'd0 : div_rem);

	always_comb begin
		we = 1'b0;
		wd = rd;
		case (cmd.code)
			tot_pkg::C_ADD: begin
				we = !full;
				wd = '{lsn: lis_q, evt: ev_q, per: per_q, acc: 32'd0};
			end
			tot_pkg::C_SHWR: we = 1'b1;
			tot_pkg::C_WRACC: begin
				we = 1'b1;
				wd = '{lsn: rd.lsn, evt: rd.evt, per: rd.per, acc: wacc};
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we && !cmd.tbl) pmem[addr[APW-1:0]] <= wd;
		if (we && cmd.tbl)  omem[addr[AOW-1:0]] <= wd;
		if ((cmd.code == tot_pkg::C_RD || cmd.code == tot_pkg::C_SHRD) && !cmd.tbl)
			rdp_q <= pmem[addr[APW-1:0]];
		if ((cmd.code == tot_pkg::C_RD || cmd.code == tot_pkg::C_SHRD) && cmd.tbl)
			rdo_q <= omem[addr[AOW-1:0]];
	end

	tot_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.code == tot_pkg::C_DIVGO),
		.dividend (acc_q),
		.divisor  (rd.per),
		.done     (div_done),
		.rem      (div_rem)
	);

	// A fired entry is held back one step so that the final one can carry last.
	always_comb begin
		push = 1'b0;
		push_data = '{status: st_q, fired_listener: lis_q, fired_event: ev_q, last: 1'b1};
		if (cmd.code == tot_pkg::C_EMIT && cmd.flush) begin
			push = 1'b1;
			push_data = '{status: tot_pkg::ST_FIRED, fired_listener: pend_lsn_q,
				fired_event: pend_evt_q, last: 1'b1};
		end else if (cmd.code == tot_pkg::C_EMIT) begin
			push = 1'b1;
		end else if (cmd.code == tot_pkg::C_FIRE && !n_full && pend_v_q) begin
			push = 1'b1;
			push_data = '{status: tot_pkg::ST_FIRED, fired_listener: pend_lsn_q,
				fired_event: pend_evt_q, last: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q   <= '0;
			ocnt_q   <= '0;
			idx_q    <= '0;
			j_q      <= '0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
			case (cmd.code)
				tot_pkg::C_LOAD: begin
					idx_q    <= '0;
					n_q      <= '0;
					pend_v_q <= 1'b0;
				end
				tot_pkg::C_ADD: begin
					if (!full && !cmd.tbl) pcnt_q <= pcnt_q + IW'(1);
					if (!full && cmd.tbl)  ocnt_q <= ocnt_q + IW'(1);
				end
				tot_pkg::C_FIRE: begin
					if (!n_full) begin
						pend_v_q <= 1'b1;
						n_q      <= n_q + tot_pkg::NW'(1);
					end
				end
				tot_pkg::C_WRACC: idx_q <= cmd.tbl ? idx_q - IW'(1) : idx_q + IW'(1);
				tot_pkg::C_NEXTP: idx_q <= idx_q + IW'(1);
				tot_pkg::C_SHINIT: j_q <= base;
				tot_pkg::C_SHWR: j_q <= j_q + IW'(1);
				tot_pkg::C_DEC: begin
					if (cmd.tbl) begin
						ocnt_q <= ocnt_q - IW'(1);
						idx_q  <= idx_q - IW'(1);
					end else begin
						pcnt_q <= pcnt_q - IW'(1);
					end
				end
				tot_pkg::C_ONCE_INIT: idx_q <= ocnt_q;
				tot_pkg::C_EMIT: if (cmd.flush) pend_v_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) out_q <= push_data;
		case (cmd.code)
			tot_pkg::C_LOAD: begin
				lis_q <= item.listener_id;
				ev_q  <= item.event_id;
				per_q <= item.period;
				el_q  <= item.elapsed;
			end
			tot_pkg::C_ADD: st_q <= full ? tot_pkg::ST_FULL : tot_pkg::ST_ADDED;
			tot_pkg::C_SUM: acc_q <= s[32] ? 32'hFFFF_FFFF : s[31:0];
			tot_pkg::C_FIRE: begin
				// Firings past the result limit are not reported, so the pending one stays.
				if (!n_full) begin
					pend_lsn_q <= rd.lsn;
					pend_evt_q <= rd.evt;
				end
			end
			tot_pkg::C_DEC:  st_q <= tot_pkg::ST_REMOVED;
			tot_pkg::C_NOTF: st_q <= tot_pkg::ST_NOT_FOUND;
			default: ;
		endcase
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	always_comb begin
		sts.i_end     = (idx_q >= pcnt_q);
		sts.o_zero    = (idx_q == '0);
		sts.shift_end = ({1'b0, j_q} + {{IW{1'b0}}, 1'b1}) >= {1'b0, cnt};
		sts.match     = (rd.lsn == lis_q) && (rd.evt == ev_q);
		sts.due       = (acc_q >= rd.per);
		sts.div_done  = div_done;
		sts.out_free  = out_free;
		sts.pend_v    = pend_v_q;
		sts.fire_ok   = n_full || !pend_v_q || out_free;
	end
endmodule

>>> rtl/tot_ctrl.sv
// Controller: sequences each operation over the datapath, one entry at a time.
module tot_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic [1:0]    item_op,
	input  tot_pkg::sts_t sts,
	output logic          item_stall,
	output tot_pkg::cmd_t cmd
);
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_ADD   = 5'd1;
	localparam logic [4:0] S_EMIT  = 5'd2;
	localparam logic [4:0] S_RRD   = 5'd3;
	localparam logic [4:0] S_RCMP  = 5'd4;
	localparam logic [4:0] S_SHRD  = 5'd5;
	localparam logic [4:0] S_SHWR  = 5'd6;
	localparam logic [4:0] S_PRD   = 5'd7;
	localparam logic [4:0] S_PSUM  = 5'd8;
	localparam logic [4:0] S_PCHK  = 5'd9;
	localparam logic [4:0] S_PFIRE = 5'd10;
	localparam logic [4:0] S_PDIV  = 5'd11;
	localparam logic [4:0] S_PWAIT = 5'd12;
	localparam logic [4:0] S_ORD   = 5'd13;
	localparam logic [4:0] S_OSUM  = 5'd14;
	localparam logic [4:0] S_OCHK  = 5'd15;
	localparam logic [4:0] S_OFIRE = 5'd16;
	localparam logic [4:0] S_OSHI  = 5'd17;
	localparam logic [4:0] S_FLUSH = 5'd18;

	logic [4:0] state_q, state_d;
	logic       tbl_q, tbl_d;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		tbl_d     = tbl_q;
		cmd.code  = tot_pkg::C_NOP;
		cmd.tbl   = tbl_q;
		cmd.flush = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.code = tot_pkg::C_LOAD;
					tbl_d    = (item_op == tot_pkg::OP_ADD_ONCE);
					case (item_op)
						tot_pkg::OP_TICK:   state_d = S_PRD;
						tot_pkg::OP_REMOVE: state_d = S_RRD;
						default:            state_d = S_ADD;
					endcase
				end
			end
			S_ADD: begin
				cmd.code = tot_pkg::C_ADD;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.code = tot_pkg::C_EMIT;
					state_d  = S_IDLE;
				end
			end
			S_RRD: begin
				if (sts.i_end) begin
					cmd.code = tot_pkg::C_NOTF;
					state_d  = S_EMIT;
				end else begin
					cmd.code = tot_pkg::C_RD;
					state_d  = S_RCMP;
				end
			end
			S_RCMP: begin
				if (sts.match) begin
					cmd.code = tot_pkg::C_SHINIT;
					state_d  = S_SHRD;
				end else begin
					cmd.code = tot_pkg::C_NEXTP;
					state_d  = S_RRD;
				end
			end
			S_SHRD: begin
				if (sts.shift_end) begin
					cmd.code = tot_pkg::C_DEC;
					state_d  = tbl_q ? S_ORD : S_EMIT;
				end else begin
					cmd.code = tot_pkg::C_SHRD;
					state_d  = S_SHWR;
				end
			end
			S_SHWR: begin
				cmd.code = tot_pkg::C_SHWR;
				state_d  = S_SHRD;
			end
			S_PRD: begin
				if (sts.i_end) begin
					cmd.code = tot_pkg::C_ONCE_INIT;
					tbl_d    = 1'b1;
					state_d  = S_ORD;
				end else begin
					cmd.code = tot_pkg::C_RD;
					state_d  = S_PSUM;
				end
			end
			S_PSUM: begin
				cmd.code = tot_pkg::C_SUM;
				state_d  = S_PCHK;
			end
			S_PCHK: begin
				if (sts.due) begin
					state_d = S_PFIRE;
				end else begin
					cmd.code = tot_pkg::C_WRACC;
					state_d  = S_PRD;
				end
			end
			S_PFIRE: begin
				if (sts.fire_ok) begin
					cmd.code = tot_pkg::C_FIRE;
					state_d  = S_PDIV;
				end
			end
			S_PDIV: begin
				cmd.code = tot_pkg::C_DIVGO;
				state_d  = S_PWAIT;
			end
			S_PWAIT: begin
				if (sts.div_done) begin
					cmd.code = tot_pkg::C_WRACC;
					state_d  = S_PRD;
				end
			end
			S_ORD: begin
				if (sts.o_zero) begin
					state_d = sts.pend_v ? S_FLUSH : S_IDLE;
				end else begin
					cmd.code = tot_pkg::C_RD;
					state_d  = S_OSUM;
				end
			end
			S_OSUM: begin
				cmd.code = tot_pkg::C_SUM;
				state_d  = S_OCHK;
			end
			S_OCHK: begin
				if (sts.due) begin
					state_d = S_OFIRE;
				end else begin
					cmd.code = tot_pkg::C_WRACC;
					state_d  = S_ORD;
				end
			end
			S_OFIRE: begin
				if (sts.fire_ok) begin
					cmd.code = tot_pkg::C_FIRE;
					state_d  = S_OSHI;
				end
			end
			S_OSHI: begin
				cmd.code = tot_pkg::C_SHINIT;
				state_d  = S_SHRD;
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.code  = tot_pkg::C_EMIT;
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tbl_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			tbl_q   <= tbl_d;
		end
	end
endmodule
